>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle as its trigger
`define CLD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cld assertion failed");

// property holds in the cycle after its trigger
`define CLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cld assertion failed");

`endif

>>> rtl/cld_pkg.sv
// shared constants, types and helpers for the caching lock directory
`default_nettype none

package cld_pkg;

   localparam int NUM_LOCKS   = 256;
   localparam int NUM_CLIENTS = 16;
   localparam int LOCK_W      = 8;
   localparam int CLIENT_W    = 4;
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int LOCK_AW     = $clog2(NUM_LOCKS);

   localparam logic FUNC_ACQUIRE = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   localparam logic [KIND_W-1:0] KIND_REPLY  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REVOKE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RETRY  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RETRY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OWNER = 2'd2;

   typedef logic [NUM_CLIENTS-1:0] client_mask_type;
   typedef logic [CLIENT_W-1:0]    client_type;
   typedef logic [LOCK_W-1:0]      lock_type;
   typedef logic [LOCK_AW-1:0]     lock_addr_type;

   typedef struct packed {
      logic            owner_valid;
      client_type      owner_client;
      client_mask_type waiting_mask;
      logic            revoke_pending;
   } dir_entry_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [STATUS_W-1:0] status;
      client_type          target_client;
      lock_type            msg_lock;
      logic                last;
   } rsp_word_type;

   typedef struct packed {
      logic          rd_en;
      lock_addr_type rd_addr;
      logic          wr_en;
      lock_addr_type wr_addr;
      dir_entry_type wr_data;
   } dir_req_type;

   // lowest set index of a waiting set
   function automatic client_type lowest_client(input client_mask_type m);
      client_type r;
      r = '0;
      for (int i = NUM_CLIENTS - 1; i >= 0; i--) begin
         if (m[i]) begin
            r = client_type'(i);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/cld_ifs.sv
// request and response channel interfaces
`default_nettype none

interface cld_req_if;
   logic                 valid;
   logic                 ready;
   logic                 func;
   cld_pkg::lock_type    lock_id;
   cld_pkg::client_type  client_id;

   modport source (output valid, output func, output lock_id, output client_id, input ready);
   modport sink (input valid, input func, input lock_id, input client_id, output ready);
endinterface

interface cld_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cld_pkg::KIND_W-1:0]     kind;
   logic [cld_pkg::STATUS_W-1:0]   status;
   cld_pkg::client_type            target_client;
   cld_pkg::lock_type              msg_lock;
   logic                           last;

   modport source (output valid, output kind, output status, output target_client,
                   output msg_lock, output last, input ready);
   modport sink (input valid, input kind, input status, input target_client,
                 input msg_lock, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/cld_dir_mem.sv
// directory entry memory with per-line valid bits
`default_nettype none

module cld_dir_mem (
   input  logic                   clock,
   input  logic                   reset,
   input  cld_pkg::dir_req_type   dir_req,
   output cld_pkg::dir_entry_type rd_entry
);

   cld_pkg::dir_entry_type entry_mem [cld_pkg::NUM_LOCKS];
   cld_pkg::dir_entry_type rd_data_ff;
   logic [cld_pkg::NUM_LOCKS-1:0] line_valid_ff, line_valid_in;
   logic rd_valid_ff;

   always_comb begin
      line_valid_in = line_valid_ff;
      if (dir_req.wr_en) begin
         line_valid_in[dir_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         line_valid_ff <= line_valid_in;
         if (dir_req.rd_en) begin
            rd_valid_ff <= line_valid_ff[dir_req.rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dir_req.wr_en) begin
         entry_mem[dir_req.wr_addr] <= dir_req.wr_data;
      end
      if (dir_req.rd_en) begin
         rd_data_ff <= entry_mem[dir_req.rd_addr];
      end
   end

   // never-written line reads as the reset entry
   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

>>> rtl/caching_lock_directory.sv
// caching lock directory top level: lock table update and message sequencing
//
//   channel   dir  handshake      word
//   req_bus   in   valid/ready    func, lock_id, client_id
//   rsp_bus   out  valid/ready    kind, status, target_client, msg_lock, last
//
// one request at a time: accept, table read, update and write, then one word per cycle while rsp_bus is not stalled
// a request emits 1 to 3 words: an optional retry, an optional revoke, then the reply
// the table read is registered: the entry is read at accept, then updated and written in ST_LOOKUP
// reset is synchronous; per-line valid bits clear the table at once, no sweep
// a stalled rsp_bus holds its word; a new request is taken while the last word waits
`default_nettype none

module caching_lock_directory (
   input  logic       clock,
   input  logic       reset,
   cld_req_if.sink    req_bus,
   cld_rsp_if.source  rsp_bus
);

   typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_EMIT} state_type;

   state_type state_ff, state_in;
   logic func_ff, func_in;
   cld_pkg::lock_type lock_ff, lock_in;
   cld_pkg::client_type client_ff, client_in;
   cld_pkg::rsp_word_type slot_ff [3];
   cld_pkg::rsp_word_type slot_in [3];
   logic [1:0] cnt_ff, cnt_in, idx_ff, idx_in, n;
   logic rsp_valid_ff, rsp_valid_in;
   cld_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   cld_pkg::dir_req_type dir_req;
   cld_pkg::dir_entry_type rd_entry, new_entry;
   logic accept, out_free, in_range, has_retry, has_revoke;
   cld_pkg::client_mask_type cl_bit, rest_mask;
   cld_pkg::client_type next_owner, revoke_to;
   logic [cld_pkg::STATUS_W-1:0] reply_status;

   cld_dir_mem u_dir_mem (
      .clock    (clock),
      .reset    (reset),
      .dir_req  (dir_req),
      .rd_entry (rd_entry)
   );

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // entry update and message selection
   always_comb begin
      in_range   = (int'(lock_ff) < cld_pkg::NUM_LOCKS) &&
                   (int'(client_ff) < cld_pkg::NUM_CLIENTS);
      cl_bit     = cld_pkg::client_mask_type'(1) << client_ff;
      next_owner = cld_pkg::lowest_client(rd_entry.waiting_mask);
      rest_mask  = rd_entry.waiting_mask & ~(cld_pkg::client_mask_type'(1) << next_owner);
      new_entry    = rd_entry;
      has_retry    = 1'b0;
      has_revoke   = 1'b0;
      revoke_to    = rd_entry.owner_client;
      reply_status = cld_pkg::ST_OK;
      if (!in_range) begin
         reply_status = (func_ff == cld_pkg::FUNC_RELEASE) ? cld_pkg::ST_OK : cld_pkg::ST_RETRY;
      end else if (func_ff == cld_pkg::FUNC_ACQUIRE) begin
         if (!rd_entry.owner_valid) begin
            new_entry.owner_valid  = 1'b1;
            new_entry.owner_client = client_ff;
            new_entry.waiting_mask = rd_entry.waiting_mask & ~cl_bit;
            if (new_entry.waiting_mask == '0) begin
               new_entry.revoke_pending = 1'b0;
            end
         end else if (rd_entry.owner_client == client_ff) begin
            reply_status = cld_pkg::ST_OWNER;
         end else begin
            new_entry.waiting_mask = rd_entry.waiting_mask | cl_bit;
            reply_status = cld_pkg::ST_RETRY;
            if (!rd_entry.revoke_pending) begin
               new_entry.revoke_pending = 1'b1;
               has_revoke = 1'b1;
            end
         end
      end else if (rd_entry.owner_valid && rd_entry.owner_client == client_ff) begin
         if (rd_entry.waiting_mask == '0) begin
            new_entry.owner_valid    = 1'b0;
            new_entry.revoke_pending = 1'b0;
         end else begin
            new_entry.owner_client   = next_owner;
            new_entry.waiting_mask   = rest_mask;
            new_entry.revoke_pending = |rest_mask;
            has_retry  = 1'b1;
            has_revoke = |rest_mask;
            revoke_to  = next_owner;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      lock_in      = lock_ff;
      client_in    = client_ff;
      slot_in      = slot_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      n            = 2'd0;
      dir_req.rd_en   = accept;
      dir_req.rd_addr = req_bus.lock_id[cld_pkg::LOCK_AW-1:0];
      dir_req.wr_en   = 1'b0;
      dir_req.wr_addr = lock_ff[cld_pkg::LOCK_AW-1:0];
      dir_req.wr_data = new_entry;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in   = req_bus.func;
               lock_in   = req_bus.lock_id;
               client_in = req_bus.client_id;
               state_in  = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            dir_req.wr_en = in_range;
            if (has_retry) begin
               slot_in[n] = '{cld_pkg::KIND_RETRY, cld_pkg::ST_OK, next_owner, lock_ff, 1'b0};
               n = n + 2'd1;
            end
            if (has_revoke) begin
               slot_in[n] = '{cld_pkg::KIND_REVOKE, cld_pkg::ST_OK, revoke_to, lock_ff, 1'b0};
               n = n + 2'd1;
            end
            slot_in[n] = '{cld_pkg::KIND_REPLY, reply_status, client_ff, lock_ff, 1'b1};
            cnt_in   = n + 2'd1;
            idx_in   = 2'd0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_word_in  = slot_ff[idx_ff];
               rsp_valid_in = 1'b1;
               idx_in       = idx_ff + 2'd1;
               if (idx_ff == cnt_ff - 2'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= 2'd0;
         idx_ff       <= 2'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
      end
      func_ff     <= func_in;
      lock_ff     <= lock_in;
      client_ff   <= client_in;
      slot_ff     <= slot_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.kind          = rsp_word_ff.kind;
   assign rsp_bus.status        = rsp_word_ff.status;
   assign rsp_bus.target_client = rsp_word_ff.target_client;
   assign rsp_bus.msg_lock      = rsp_word_ff.msg_lock;
   assign rsp_bus.last          = rsp_word_ff.last;

endmodule

`default_nettype wire

>>> rtl/cld_checker.sv
// port-level checker for the caching lock directory and its bind
`default_nettype none

`include "assert_macros.svh"

module cld_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [cld_pkg::KIND_W-1:0]     rsp_kind,
   input logic [cld_pkg::STATUS_W-1:0]   rsp_status,
   input cld_pkg::client_type            rsp_target,
   input cld_pkg::lock_type              rsp_lock,
   input logic                           rsp_last
);

   `CLD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CLD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable({rsp_kind, rsp_status, rsp_target, rsp_lock, rsp_last}))
   `CLD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `CLD_ASSERT_SAME(a_msg_format, clock, reset, rsp_valid && rsp_kind != cld_pkg::KIND_REPLY, rsp_status == cld_pkg::ST_OK && !rsp_last)

endmodule

bind caching_lock_directory cld_checker u_cld_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_kind   (rsp_bus.kind),
   .rsp_status (rsp_bus.status),
   .rsp_target (rsp_bus.target_client),
   .rsp_lock   (rsp_bus.msg_lock),
   .rsp_last   (rsp_bus.last)
);

`default_nettype wire
